@@ src/gab_pkg.sv @@
// Shared types and constants for the gray-out alpha blend pixel pipeline.
`default_nettype none

package gab_pkg;

	// Pixel format codes held in the format register.
	typedef enum logic {
		FMT_XRGB8888 = 1'b0,
		FMT_RGB565   = 1'b1
	} pix_fmt_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_BLEND_ALPHA  = 2'd0,
		REG_PIXEL_FORMAT = 2'd1
	} cfg_reg_t;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 8;

	// Q16 gray weights, rounded to nearest.
	localparam logic [15:0] W32_R = 16'd6554;
	localparam logic [15:0] W32_G = 16'd12452;
	localparam logic [15:0] W32_B = 16'd655;
	localparam logic [15:0] W16_R = 16'd19661;
	localparam logic [15:0] W16_G = 16'd38666;
	localparam logic [15:0] W16_B = 16'd7209;

	// Live configuration as seen by the pipeline.
	typedef struct packed {
		logic [7:0] alpha;
		pix_fmt_t   fmt;
	} cfg_t;

	// Item handed from the gray unit to the mixing unit.
	typedef struct packed {
		logic [7:0] s_r;
		logic [7:0] s_g;
		logic [7:0] s_b;
		logic [7:0] gray;
		logic [7:0] d_rb;
		logic [7:0] d_g;
	} gray_item_t;

endpackage

`default_nettype wire

@@ src/gab_gray.sv @@
// Two pipeline stages: channel extraction with weight products, then the gray sum.
`default_nettype none

module gab_gray import gab_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [31:0] in_pixel,
	output logic            out_valid,
	input  wire logic       out_ready,
	output gray_item_t      out_item
);

	logic        en_s1, en_s2;
	logic        valid_s1, valid_s2;
	logic [7:0]  sr, sg, sb;
	logic [15:0] wr, wg, wb;
	logic [23:0] pr, pg, pb;
	logic [7:0]  sr_s1, sg_s1, sb_s1;
	logic [23:0] pr_s1, pg_s1, pb_s1;
	logic [24:0] sum;
	logic [7:0]  gray;
	gray_item_t  item_s2;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		if (cfg.fmt == FMT_RGB565) begin
			// Expand 5 and 6 bit fields by copying their high bits down.
			sr = {in_pixel[15:11], in_pixel[15:13]};
			sg = {in_pixel[10:5], in_pixel[10:9]};
			sb = {in_pixel[4:0], in_pixel[4:2]};
			wr = W16_R;
			wg = W16_G;
			wb = W16_B;
		end else begin
			sr = in_pixel[23:16];
			sg = in_pixel[15:8];
			sb = in_pixel[7:0];
			wr = W32_R;
			wg = W32_G;
			wb = W32_B;
		end
		pr = {8'b0, wr} * {16'b0, sr};
		pg = {8'b0, wg} * {16'b0, sg};
		pb = {8'b0, wb} * {16'b0, sb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sr_s1 <= sr;
			sg_s1 <= sg;
			sb_s1 <= sb;
			pr_s1 <= pr;
			pg_s1 <= pg;
			pb_s1 <= pb;
		end
	end

	always_comb begin
		sum  = {1'b0, pr_s1} + {1'b0, pg_s1} + {1'b0, pb_s1};
		gray = sum[23:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2.s_r  <= sr_s1;
			item_s2.s_g  <= sg_s1;
			item_s2.s_b  <= sb_s1;
			item_s2.gray <= gray;
			// The gray packed to 565 and expanded again.
			item_s2.d_rb <= {gray[7:3], gray[7:5]};
			item_s2.d_g  <= {gray[7:2], gray[7:6]};
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

`default_nettype wire

@@ src/gab_mix.sv @@
// Two pipeline stages: alpha products, then rounding, clamping and repacking.
`default_nettype none

module gab_mix import gab_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire gray_item_t  in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      out_pixel
);

	logic               en_s3, en_s4;
	logic               valid_s3, valid_s4;
	logic [7:0]         s   [3];
	logic [7:0]         d   [3];
	logic [7:0]         inv_alpha;
	logic [15:0]        m1  [3];
	logic [15:0]        m2;
	logic signed [17:0] xs  [3];
	logic signed [17:0] as;
	logic signed [17:0] xm  [3];
	logic [15:0]        m1_s3 [3];
	logic [15:0]        m2_s3;
	logic signed [17:0] xm_s3 [3];
	logic [7:0]         d_s3  [3];
	logic [16:0]        u1  [3];
	logic [16:0]        t1  [3];
	logic [16:0]        u2;
	logic [16:0]        t2;
	logic [9:0]         sum32 [3];
	logic [7:0]         c32 [3];
	logic signed [17:0] v   [3];
	logic signed [17:0] w   [3];
	logic signed [17:0] r16 [3];
	logic [7:0]         c16 [3];
	logic [31:0]        pix;
	logic [31:0]        pixel_s4;

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign in_ready = en_s3;

	always_comb begin
		s[0] = in_item.s_r;
		s[1] = in_item.s_g;
		s[2] = in_item.s_b;
		d[0] = in_item.d_rb;
		d[1] = in_item.d_g;
		d[2] = in_item.d_rb;
		inv_alpha = 8'd255 - cfg.alpha;
		m2 = {8'b0, in_item.gray} * {8'b0, inv_alpha};
		as = $signed({10'b0, cfg.alpha});
		for (int i = 0; i < 3; i++) begin
			m1[i] = {8'b0, s[i]} * {8'b0, cfg.alpha};
			xs[i] = $signed({10'b0, s[i]}) - $signed({10'b0, d[i]});
			xm[i] = xs[i] * as;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			m2_s3 <= m2;
			for (int i = 0; i < 3; i++) begin
				m1_s3[i] <= m1[i];
				xm_s3[i] <= xm[i];
				d_s3[i]  <= d[i];
			end
		end
	end

	always_comb begin
		// Rounded division by 255 of the gray term, shared by all channels.
		u2 = {1'b0, m2_s3} + 17'h80;
		t2 = u2 + {8'b0, u2[16:8]};
		for (int i = 0; i < 3; i++) begin
			u1[i]    = {1'b0, m1_s3[i]} + 17'h80;
			t1[i]    = u1[i] + {8'b0, u1[i][16:8]};
			sum32[i] = {1'b0, t1[i][16:8]} + {1'b0, t2[16:8]};
			c32[i]   = (sum32[i] > 10'd255) ? 8'hff : sum32[i][7:0];
			// Signed version: floor shifts on a difference that may be negative.
			v[i]   = xm_s3[i] + 18'sd128;
			w[i]   = v[i] + (v[i] >>> 8);
			r16[i] = (w[i] >>> 8) + $signed({10'b0, d_s3[i]});
			if (r16[i] < 18'sd0) begin
				c16[i] = 8'd0;
			end else if (r16[i] > 18'sd255) begin
				c16[i] = 8'hff;
			end else begin
				c16[i] = r16[i][7:0];
			end
		end
		if (cfg.fmt == FMT_RGB565) begin
			pix = {16'b0, c16[0][7:3], c16[1][7:2], c16[2][7:3]};
		end else begin
			pix = {8'hff, c32[0], c32[1], c32[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			pixel_s4 <= pix;
		end
	end

	assign out_valid = valid_s4;
	assign out_pixel = pixel_s4;

endmodule

`default_nettype wire

@@ src/grayout_alpha_blend_pixel.sv @@
// Top level of the gray-out alpha blend pixel pipeline with its configuration registers.
//
// Blends each pixel toward its own gray version by the blend_alpha register (255 keeps
// the pixel, 0 gives full gray), for x8r8g8b8 or r5g6b5 pixels as pixel_format selects.
// The datapath is a four-stage pipeline: weight products, gray sum, alpha products, then
// rounding, clamping and repacking. One pixel is taken every clock while the output side
// keeps up. The last stage is the output register; an empty stage anywhere lets a new
// pixel in while a result waits.
// Backpressure from m_axis_tready reaches s_axis_tready through the stage enables.
// Configuration writes are taken every cycle and apply at once, so they belong in times
// when no pixel is in flight.
`default_nettype none

module grayout_alpha_blend_pixel import gab_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [31:0]         s_axis_tdata,   // [31:0] pixel_in
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [31:0]              m_axis_tdata    // [31:0] pixel_out
);

	logic [7:0] alpha_q;
	pix_fmt_t   fmt_q;
	cfg_t       cfg;
	logic       mid_valid, mid_ready;
	gray_item_t mid_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 8'hff;
			fmt_q   <= FMT_XRGB8888;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLEND_ALPHA:  alpha_q <= cfg_data;
				REG_PIXEL_FORMAT: fmt_q   <= pix_fmt_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	assign cfg.alpha = alpha_q;
	assign cfg.fmt   = fmt_q;

	gab_gray u_gray (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pixel  (s_axis_tdata),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_item  (mid_item)
	);

	gab_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_item   (mid_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pixel (m_axis_tdata)
	);

endmodule

`default_nettype wire

@@ src/gab_checker.sv @@
// Port-level checker for the gray-out alpha blend pipeline, bound to the top level.
`default_nettype none

module gab_checker import gab_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cfg_valid,
	input wire logic                cfg_ready,
	input wire logic [CfgIdxW-1:0]  cfg_index,
	input wire logic [CfgDataW-1:0] cfg_data,
	input wire logic                s_axis_tvalid,
	input wire logic                s_axis_tready,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [31:0]         m_axis_tdata
);

	localparam logic [2:0] MaxInFlight = 3'd4;

	logic [2:0] inflight_q;
	pix_fmt_t   fmt_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	// Mirror of the format register, written the same way as in the block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_XRGB8888;
		end else if (cfg_valid && cfg_ready && cfg_index == REG_PIXEL_FORMAT) begin
			fmt_q <= pix_fmt_t'(cfg_data[0]);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transfer withdrawn while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 3'd0)
		else $error("result presented with no pixel in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= MaxInFlight)
		else $error("more pixels in flight than pipeline stages");

	a_fmt32: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && fmt_q == FMT_XRGB8888 |-> m_axis_tdata[31:24] == 8'hff)
		else $error("x8r8g8b8 result lacks an opaque alpha byte");

	a_fmt16: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && fmt_q == FMT_RGB565 |-> m_axis_tdata[31:16] == 16'h0)
		else $error("r5g6b5 result has upper bits set");

endmodule

bind grayout_alpha_blend_pixel gab_checker u_gab_checker (.*);

`default_nettype wire
